// File: rtl/pit_pkg.sv
// shared types, constants and microcode program of the periodic interval timer
package pit_pkg;

  localparam int PC_W   = 4;
  localparam int CNT_W  = 5;
  localparam int WORD_W = 32;

  localparam logic [WORD_W-1:0] PCT_SCALE   = 32'd100;
  localparam logic [WORD_W-1:0] MS_PER_MS   = 32'd1;
  localparam logic [WORD_W-1:0] MS_PER_SEC  = 32'd1000;
  localparam logic [WORD_W-1:0] MS_PER_MIN  = 32'd1000 * 32'd60;
  localparam logic [WORD_W-1:0] MS_PER_HOUR = 32'd1000 * 32'd60 * 32'd60;

  localparam logic [1:0] UNIT_MS   = 2'd0;
  localparam logic [1:0] UNIT_SEC  = 2'd1;
  localparam logic [1:0] UNIT_MIN  = 2'd2;
  localparam logic [1:0] UNIT_HOUR = 2'd3;

  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_REPEAT   = 1'b1;

  localparam logic [31:0] INTERVAL_RST = 32'd1000;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 80;

  localparam logic [PC_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [PC_W-1:0] STEP_EMIT = 4'd11;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_UPDATE,
    OP_LOAD_PCT,
    OP_LOAD_MAP,
    OP_LOAD_REM,
    OP_DIV,
    OP_STORE_PCT,
    OP_STORE_MAP,
    OP_STORE_REM,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_IN,
    COND_SHORT,
    COND_LOOP,
    COND_OUT
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  function automatic ctrl_t rom(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '{op: OP_NONE, cond: COND_OUT, target: STEP_IDLE};
    case (pc)
      4'd0:    c = '{op: OP_CAPTURE,   cond: COND_IN,    target: STEP_IDLE};
      4'd1:    c = '{op: OP_UPDATE,    cond: COND_SHORT, target: STEP_EMIT};
      4'd2:    c = '{op: OP_LOAD_PCT,  cond: COND_NEXT,  target: STEP_IDLE};
      4'd3:    c = '{op: OP_DIV,       cond: COND_LOOP,  target: STEP_IDLE};
      4'd4:    c = '{op: OP_STORE_PCT, cond: COND_NEXT,  target: STEP_IDLE};
      4'd5:    c = '{op: OP_LOAD_MAP,  cond: COND_NEXT,  target: STEP_IDLE};
      4'd6:    c = '{op: OP_DIV,       cond: COND_LOOP,  target: STEP_IDLE};
      4'd7:    c = '{op: OP_STORE_MAP, cond: COND_NEXT,  target: STEP_IDLE};
      4'd8:    c = '{op: OP_LOAD_REM,  cond: COND_NEXT,  target: STEP_IDLE};
      4'd9:    c = '{op: OP_DIV,       cond: COND_LOOP,  target: STEP_IDLE};
      4'd10:   c = '{op: OP_STORE_REM, cond: COND_NEXT,  target: STEP_IDLE};
      4'd11:   c = '{op: OP_EMIT,      cond: COND_OUT,   target: STEP_IDLE};
      default: c = '{op: OP_NONE,      cond: COND_OUT,   target: STEP_IDLE};
    endcase
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] unit_div(input logic [1:0] unit);
    logic [WORD_W-1:0] d;
    unique case (unit)
      UNIT_MS:   d = MS_PER_MS;
      UNIT_SEC:  d = MS_PER_SEC;
      UNIT_MIN:  d = MS_PER_MIN;
      UNIT_HOUR: d = MS_PER_HOUR;
      default:   d = MS_PER_MS;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/periodic_interval_timer.sv
// periodic interval timer with one-shot mode, run by a microcoded sequencer
// An input beat is taken when the sequencer sits at its idle step. A beat that
// needs no division (paused, fire time ahead of now, period over, zero interval)
// goes from the update step straight to the emit step, and the sequencer then
// returns to its idle step for the next beat. Otherwise one shared radix-2
// restoring divider produces the percent, the mapped value and the remaining
// time in turn, one iteration per quotient bit, the first two fed by one 32x32
// multiplier. The result sits in an output register, so the next beat is
// taken while it waits; a stalled output holds the sequencer at its emit step.
module periodic_interval_timer #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // now_ms[31:0], pause_cmd[32], resume_cmd[33], take_ready[34],
  // map_source[66:35], map_target[98:67], zero fill[103:99]
  input  logic [pit_pkg::IN_TDATA_W-1:0] in_tdata,
  // time_unit[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // fired[0], ready_seen[1], is_paused[2], remaining_time[34:3],
  // percent_done[41:35], mapped_value[73:42], zero fill[79:74]
  output logic [pit_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  pit_pkg::ctrl_t ctrl;

  logic [pit_pkg::PC_W-1:0]  pc_r, pc_nxt;
  logic [pit_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [TIME_BITS-1:0]      last_r, last_nxt;
  logic                      paused_r, paused_nxt;
  logic                      ready_r, ready_nxt;
  logic [31:0]               interval_r;
  logic                      repeat_r;

  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic                 pause_r, pause_nxt;
  logic                 resume_r, resume_nxt;
  logic                 take_r, take_nxt;
  logic [1:0]           unit_r, unit_nxt;
  logic [31:0]          src_r, src_nxt;
  logic [31:0]          tgt_r, tgt_nxt;
  logic [31:0]          passed_r, passed_nxt;
  logic [31:0]          gap_r, gap_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [31:0]          quo_r, quo_nxt;
  logic [31:0]          dvs_r, dvs_nxt;

  logic        res_fired_r, res_fired_nxt;
  logic        res_seen_r, res_seen_nxt;
  logic        res_paused_r, res_paused_nxt;
  logic [31:0] res_rem_r, res_rem_nxt;
  logic [6:0]  res_pct_r, res_pct_nxt;
  logic [31:0] res_map_r, res_map_nxt;

  logic [pit_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                 cfg_wr;
  logic                 in_beat;
  logic                 out_free;
  logic                 short_c;
  logic [TIME_BITS-1:0] ivl;
  logic [TIME_BITS-1:0] last_n;
  logic [TIME_BITS-1:0] end_t;
  logic                 p_n;
  logic                 fire;
  logic                 rdy_n;
  logic [31:0]          span;
  logic [31:0]          mul_b;
  logic [63:0]          prod;
  logic [32:0]          shl;

  assign ctrl       = pit_pkg::rom(pc_r);
  assign in_tready  = (ctrl.cond == pit_pkg::COND_IN);
  assign in_beat    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == pit_pkg::REG_REPEAT) ? {31'd0, repeat_r} : interval_r;

  assign ivl   = TIME_BITS'(interval_r);
  assign span  = tgt_r - src_r + 32'd1;
  assign mul_b = (ctrl.op == pit_pkg::OP_LOAD_MAP) ? span : pit_pkg::PCT_SCALE;
  assign prod  = 64'(passed_r) * 64'(mul_b);
  assign shl   = {rem_r, quo_r[31]};

  always_comb begin
    pc_nxt         = pc_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    last_nxt       = last_r;
    paused_nxt     = paused_r;
    ready_nxt      = ready_r;
    now_nxt        = now_r;
    pause_nxt      = pause_r;
    resume_nxt     = resume_r;
    take_nxt       = take_r;
    unit_nxt       = unit_r;
    src_nxt        = src_r;
    tgt_nxt        = tgt_r;
    passed_nxt     = passed_r;
    gap_nxt        = gap_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    dvs_nxt        = dvs_r;
    res_fired_nxt  = res_fired_r;
    res_seen_nxt   = res_seen_r;
    res_paused_nxt = res_paused_r;
    res_rem_nxt    = res_rem_r;
    res_pct_nxt    = res_pct_r;
    res_map_nxt    = res_map_r;
    short_c        = 1'b0;
    p_n            = paused_r;
    fire           = 1'b0;
    rdy_n          = ready_r;
    last_n         = last_r;
    end_t          = last_r + ivl;

    unique case (ctrl.op) inside
      pit_pkg::OP_CAPTURE: begin
        if (in_beat) begin
          now_nxt    = TIME_BITS'(in_tdata[31:0]);
          pause_nxt  = in_tdata[32];
          resume_nxt = in_tdata[33];
          take_nxt   = in_tdata[34];
          src_nxt    = in_tdata[66:35];
          tgt_nxt    = in_tdata[98:67];
          unit_nxt   = in_tuser;
        end
      end
      pit_pkg::OP_UPDATE: begin
        if (resume_r) p_n = 1'b0;
        if (pause_r) p_n = 1'b1;
        if (!p_n) begin
          if ((now_r - last_r) >= ivl) begin
            fire   = 1'b1;
            last_n = now_r;
            rdy_n  = 1'b1;
            if (!repeat_r) p_n = 1'b1;
          end else if (now_r < last_r) begin
            last_n = now_r;
          end
        end
        res_seen_nxt = take_r && rdy_n;
        if (take_r) rdy_n = 1'b0;
        end_t          = last_n + ivl;
        last_nxt       = last_n;
        paused_nxt     = p_n;
        ready_nxt      = rdy_n;
        res_fired_nxt  = fire;
        res_paused_nxt = p_n;
        res_rem_nxt    = '0;
        res_pct_nxt    = '0;
        res_map_nxt    = '0;
        passed_nxt     = 32'(now_r - last_n);
        gap_nxt        = 32'(end_t - now_r);
        short_c        = 1'b1;
        if (!p_n) begin
          if (last_n > now_r) begin
            res_map_nxt = src_r;
          end else if (end_t > now_r && ivl != '0) begin
            short_c = 1'b0;
          end else begin
            res_pct_nxt = pit_pkg::PCT_SCALE[6:0];
            res_map_nxt = tgt_r;
          end
        end
      end
      pit_pkg::OP_LOAD_PCT, pit_pkg::OP_LOAD_MAP: begin
        rem_nxt = prod[63:32];
        quo_nxt = prod[31:0];
        dvs_nxt = 32'(ivl);
        cnt_nxt = '0;
      end
      pit_pkg::OP_LOAD_REM: begin
        rem_nxt = '0;
        quo_nxt = gap_r;
        dvs_nxt = pit_pkg::unit_div(unit_r);
        cnt_nxt = '0;
      end
      pit_pkg::OP_DIV: begin
        if (shl >= {1'b0, dvs_r}) begin
          rem_nxt = 32'(shl - {1'b0, dvs_r});
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = shl[31:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      pit_pkg::OP_STORE_PCT: res_pct_nxt = quo_r[6:0];
      pit_pkg::OP_STORE_MAP: res_map_nxt = src_r + quo_r;
      pit_pkg::OP_STORE_REM: res_rem_nxt = quo_r;
      pit_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, res_map_r, res_pct_r, res_rem_r,
                           res_paused_r, res_seen_r, res_fired_r};
        end
      end
      default: begin
      end
    endcase

    unique case (ctrl.cond)
      pit_pkg::COND_NEXT:  pc_nxt = pc_r + 1'b1;
      pit_pkg::COND_IN:    if (in_beat) pc_nxt = pc_r + 1'b1;
      pit_pkg::COND_SHORT: pc_nxt = short_c ? ctrl.target : pc_r + 1'b1;
      pit_pkg::COND_LOOP:  if (cnt_r == '1) pc_nxt = pc_r + 1'b1;
      pit_pkg::COND_OUT:   if (out_free) pc_nxt = ctrl.target;
      default:             pc_nxt = pit_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= pit_pkg::STEP_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      last_r      <= '0;
      paused_r    <= 1'b0;
      ready_r     <= 1'b0;
      interval_r  <= pit_pkg::INTERVAL_RST;
      repeat_r    <= 1'b1;
    end else begin
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      paused_r    <= paused_nxt;
      ready_r     <= ready_nxt;
      if (cfg_wr) begin
        unique case (cfg_paddr[2])
          pit_pkg::REG_INTERVAL: interval_r <= cfg_pwdata;
          pit_pkg::REG_REPEAT:   repeat_r   <= cfg_pwdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r        <= now_nxt;
    pause_r      <= pause_nxt;
    resume_r     <= resume_nxt;
    take_r       <= take_nxt;
    unit_r       <= unit_nxt;
    src_r        <= src_nxt;
    tgt_r        <= tgt_nxt;
    passed_r     <= passed_nxt;
    gap_r        <= gap_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    dvs_r        <= dvs_nxt;
    res_fired_r  <= res_fired_nxt;
    res_seen_r   <= res_seen_nxt;
    res_paused_r <= res_paused_nxt;
    res_rem_r    <= res_rem_nxt;
    res_pct_r    <= res_pct_nxt;
    res_map_r    <= res_map_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule
